/* rtl/mcr_pkg.sv */
package mcr_pkg;

   localparam int RADIUS_BITS = 12;
   localparam int STEP_X_W    = RADIUS_BITS + 1;
   localparam int STEP_Y_W    = RADIUS_BITS + 2;
   localparam int DEC_W       = RADIUS_BITS + 4;
   localparam int CENTER_W    = 15;
   localparam int COORD_W     = CENTER_W + 2;
   localparam int DIM_W       = 13;
   localparam int PIX_W       = 12;
   localparam int COLOR_W     = 16;
   localparam int PIX_IDX_W   = 3;

   localparam logic [PIX_IDX_W-1:0] PIX_LAST = PIX_IDX_W'(7);

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(240);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(320);

   typedef struct packed {
      logic                       idle;
      logic [STEP_X_W-1:0]        x;
      logic [STEP_X_W-1:0]        y;
      logic signed [CENTER_W-1:0] cx;
      logic signed [CENTER_W-1:0] cy;
      logic [COLOR_W-1:0]         color;
      logic                       done;
   } job_type;

   typedef struct packed {
      logic [PIX_W-1:0]   px;
      logic [PIX_W-1:0]   py;
      logic [COLOR_W-1:0] color;
      logic               valid;
      logic               last;
      logic               done;
   } pixel_type;

endpackage

/* rtl/mcr_iter.sv */
module mcr_iter
   import mcr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  logic                       step,
   input  logic signed [CENTER_W-1:0] center_x,
   input  logic signed [CENTER_W-1:0] center_y,
   input  logic [RADIUS_BITS-1:0]     radius,
   input  logic [COLOR_W-1:0]         pen_color,
   output job_type                    snap
);

   logic [STEP_X_W-1:0]        x_ff, x_in;
   logic [STEP_Y_W-1:0]        y_ff, y_in;
   logic [DEC_W-1:0]           d_ff, d_in;
   logic signed [CENTER_W-1:0] cx_ff, cx_in;
   logic signed [CENTER_W-1:0] cy_ff, cy_in;
   logic [COLOR_W-1:0]         color_ff, color_in;
   logic                       busy_ff, busy_in;

   logic [DEC_W-1:0]    x_s, y_s, d_next;
   logic [STEP_X_W-1:0] x_next;
   logic [STEP_Y_W-1:0] y_next;
   logic                done;

   always_comb begin
      x_s    = {{(DEC_W-STEP_X_W){1'b0}}, x_ff};
      y_s    = {{(DEC_W-STEP_Y_W){y_ff[STEP_Y_W-1]}}, y_ff};
      x_next = x_ff + STEP_X_W'(1);
      if (d_ff[DEC_W-1]) begin
         d_next = d_ff + (x_s << 2) + DEC_W'(6);
         y_next = y_ff;
      end else begin
         d_next = d_ff + ((x_s - y_s) << 2) + DEC_W'(10);
         y_next = y_ff - STEP_Y_W'(1);
      end
      done = $signed({1'b0, x_next}) > $signed(y_next);
   end

   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      d_in     = d_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      color_in = color_ff;
      busy_in  = busy_ff;
      if (load) begin
         x_in     = '0;
         y_in     = {{(STEP_Y_W-RADIUS_BITS){1'b0}}, radius};
         d_in     = DEC_W'(3) - ({{(DEC_W-RADIUS_BITS){1'b0}}, radius} << 1);
         cx_in    = center_x;
         cy_in    = center_y;
         color_in = pen_color;
         busy_in  = 1'b1;
      end else if (step && busy_ff) begin
         x_in    = x_next;
         y_in    = y_next;
         d_in    = d_next;
         busy_in = !done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      x_ff     <= x_in;
      y_ff     <= y_in;
      d_ff     <= d_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      color_ff <= color_in;
   end

   // snapshot of the current iteration, before the update
   always_comb begin
      snap.idle  = !busy_ff;
      snap.x     = x_ff;
      snap.y     = y_ff[STEP_X_W-1:0];
      snap.cx    = cx_ff;
      snap.cy    = cy_ff;
      snap.color = color_ff;
      snap.done  = busy_ff ? done : 1'b1;
   end

endmodule

/* rtl/mcr_pixel.sv */
module mcr_pixel
   import mcr_pkg::*;
(
   input  job_type              job,
   input  logic [PIX_IDX_W-1:0] idx,
   input  logic [DIM_W-1:0]     screen_width,
   input  logic [DIM_W-1:0]     screen_height,
   output pixel_type            pix
);

   logic [STEP_X_W-1:0] off_h, off_v;
   logic [COORD_W-1:0]  cx_e, cy_e, oh_e, ov_e, px_c, py_c;
   logic                ok;

   // idx[2] swaps the axes, idx[0] mirrors x, idx[1] mirrors y
   always_comb begin
      off_h = idx[2] ? job.y : job.x;
      off_v = idx[2] ? job.x : job.y;
      cx_e  = {{(COORD_W-CENTER_W){job.cx[CENTER_W-1]}}, job.cx};
      cy_e  = {{(COORD_W-CENTER_W){job.cy[CENTER_W-1]}}, job.cy};
      oh_e  = {{(COORD_W-STEP_X_W){1'b0}}, off_h};
      ov_e  = {{(COORD_W-STEP_X_W){1'b0}}, off_v};
      px_c  = idx[0] ? cx_e - oh_e : cx_e + oh_e;
      py_c  = idx[1] ? cy_e - ov_e : cy_e + ov_e;
      ok    = !job.idle
              && !px_c[COORD_W-1] && !py_c[COORD_W-1]
              && (px_c < {{(COORD_W-DIM_W){1'b0}}, screen_width})
              && (py_c < {{(COORD_W-DIM_W){1'b0}}, screen_height})
              && (px_c[COORD_W-2:PIX_W] == '0)
              && (py_c[COORD_W-2:PIX_W] == '0);
      pix.px    = ok ? px_c[PIX_W-1:0] : '0;
      pix.py    = ok ? py_c[PIX_W-1:0] : '0;
      pix.color = job.idle ? '0 : job.color;
      pix.valid = ok;
      pix.last  = job.idle || (idx == PIX_LAST);
      pix.done  = job.done;
   end

endmodule

/* rtl/midpoint_circle_rasterizer_core.sv */
// A step request's pixels pass through the job register and then the rsp output register.
// Output: a step gives eight pixels, one pixel per cycle from the output register while
// rsp_tready allows; start requests give no output; an idle step gives one result.
// Reset: synchronous, active high; returns to idle, screen size 240 x 320.
module midpoint_circle_rasterizer_core
   import mcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // center_x, center_y, radius, pen_color, zero pad
   input  logic [0:0]  req_tuser,  // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // pixel_x, pixel_y, pixel_color
   output logic [1:0]  rsp_tuser,  // pixel_valid, circle_done
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [12:0] csr_data
);

   logic [DIM_W-1:0]     width_ff, width_in;
   logic [DIM_W-1:0]     height_ff, height_in;
   logic                 job_valid_ff, job_valid_in;
   job_type              job_ff, job_in;
   logic [PIX_IDX_W-1:0] idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   pixel_type            rsp_ff, rsp_in;

   job_type   snap;
   pixel_type pix;
   logic      advance, job_end, req_fire, load, step;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WIDTH:  width_in  = csr_data;
            CSR_HEIGHT: height_in = csr_data;
            default:    width_in  = width_ff;
         endcase
      end
   end

   assign advance    = job_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign job_end    = advance && pix.last;
   assign req_tready = !job_valid_ff || job_end;
   assign req_fire   = req_tvalid && req_tready;
   assign load       = req_fire && (req_tuser[0] == OP_START);
   assign step       = req_fire && (req_tuser[0] == OP_STEP);

   mcr_iter u_iter (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .step      (step),
      .center_x  (req_tdata[14:0]),
      .center_y  (req_tdata[29:15]),
      .radius    (RADIUS_BITS'(req_tdata[41:30])),
      .pen_color (req_tdata[57:42]),
      .snap      (snap)
   );

   mcr_pixel u_pixel (
      .job           (job_ff),
      .idx           (idx_ff),
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .pix           (pix)
   );

   always_comb begin
      job_valid_in = job_valid_ff;
      job_in       = job_ff;
      idx_in       = idx_ff;
      if (job_end) begin
         job_valid_in = 1'b0;
      end else if (advance) begin
         idx_in = idx_ff + PIX_IDX_W'(1);
      end
      if (step) begin
         job_valid_in = 1'b1;
         job_in       = snap;
         idx_in       = '0;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_in       = pix;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         job_valid_ff <= job_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff <= job_in;
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.color, rsp_ff.py, rsp_ff.px};
   assign rsp_tuser  = {rsp_ff.done, rsp_ff.valid};
   assign rsp_tlast  = rsp_ff.last;

endmodule

/* tb/circle_pixel_checker.sv */
`timescale 1ns / 100ps
module circle_pixel_checker
   import mcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic [0:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [12:0] csr_data,
   output int          fail_count,
   output int          pending,
   output int          compared
);

   localparam int PIX_SPAN = 1 << PIX_W;

   pixel_type          pixel_queue[$];
   int                 scr_w;
   int                 scr_h;
   int                 cur_x;
   int                 cur_y;
   int                 dec;
   int                 ctr_x;
   int                 ctr_y;
   logic [COLOR_W-1:0] pen;
   logic               active;
   int                 errors;
   int                 n_checked;

   function automatic pixel_type plot(int px, int py, logic last, logic done);
      pixel_type p;
      logic      on_screen;
      on_screen = px >= 0 && py >= 0 && px < scr_w && py < scr_h &&
                  px < PIX_SPAN && py < PIX_SPAN;
      p.px    = on_screen ? PIX_W'(px) : '0;
      p.py    = on_screen ? PIX_W'(py) : '0;
      p.color = pen;
      p.valid = on_screen;
      p.last  = last;
      p.done  = done;
      return p;
   endfunction

   task automatic advance_circle(logic op, logic [63:0] d);
      int        r;
      int        x;
      int        y;
      logic      done;
      pixel_type idle_pix;
      if (op == OP_START) begin
         r      = int'(d[41:30]) & ((1 << RADIUS_BITS) - 1);
         ctr_x  = $signed(d[14:0]);
         ctr_y  = $signed(d[29:15]);
         pen    = d[57:42];
         cur_x  = 0;
         cur_y  = r;
         dec    = 3 - 2 * r;
         active = 1'b1;
      end else if (!active) begin
         idle_pix      = '0;
         idle_pix.last = 1'b1;
         idle_pix.done = 1'b1;
         pixel_queue.push_back(idle_pix);
      end else begin
         x = cur_x;
         y = cur_y;
         if (dec < 0) begin
            dec = dec + 4 * x + 6;
         end else begin
            dec   = dec + 4 * (x - y) + 10;
            cur_y = y - 1;
         end
         cur_x = x + 1;
         done  = cur_x > cur_y;
         if (done) begin
            active = 1'b0;
         end
         pixel_queue.push_back(plot(ctr_x + x, ctr_y + y, 1'b0, done));
         pixel_queue.push_back(plot(ctr_x - x, ctr_y + y, 1'b0, done));
         pixel_queue.push_back(plot(ctr_x + x, ctr_y - y, 1'b0, done));
         pixel_queue.push_back(plot(ctr_x - x, ctr_y - y, 1'b0, done));
         pixel_queue.push_back(plot(ctr_x + y, ctr_y + x, 1'b0, done));
         pixel_queue.push_back(plot(ctr_x - y, ctr_y + x, 1'b0, done));
         pixel_queue.push_back(plot(ctr_x + y, ctr_y - x, 1'b0, done));
         pixel_queue.push_back(plot(ctr_x - y, ctr_y - x, 1'b1, done));
      end
   endtask

   task automatic check_pixel(pixel_type got);
      pixel_type want;
      if (pixel_queue.size() == 0) begin
         errors++;
         if (errors <= 10) begin
            $display("%0t: unexpected pixel x=%0d y=%0d color=%h valid=%b last=%b done=%b",
                     $realtime, got.px, got.py, got.color, got.valid, got.last, got.done);
         end
      end else begin
         want = pixel_queue.pop_front();
         n_checked++;
         if (got.px !== want.px || got.py !== want.py || got.color !== want.color ||
             got.valid !== want.valid || got.last !== want.last || got.done !== want.done) begin
            errors++;
            if (errors <= 10) begin
               $display("%0t: pixel mismatch, expected x=%0d y=%0d color=%h valid=%b last=%b done=%b",
                        $realtime, want.px, want.py, want.color, want.valid, want.last,
                        want.done);
               $display("%0t:                 actual x=%0d y=%0d color=%h valid=%b last=%b done=%b",
                        $realtime, got.px, got.py, got.color, got.valid, got.last, got.done);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         scr_w     = int'(WIDTH_RESET);
         scr_h     = int'(HEIGHT_RESET);
         cur_x     = 0;
         cur_y     = 0;
         dec       = 0;
         ctr_x     = 0;
         ctr_y     = 0;
         pen       = '0;
         active    = 1'b0;
         errors    = 0;
         n_checked = 0;
         pixel_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_WIDTH) begin
               scr_w = int'(csr_data);
            end else begin
               scr_h = int'(csr_data);
            end
         end
         if (req_tvalid && req_tready) begin
            advance_circle(req_tuser[0], req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            check_pixel('{px: rsp_tdata[11:0], py: rsp_tdata[23:12],
                          color: rsp_tdata[39:24], valid: rsp_tuser[0],
                          last: rsp_tlast, done: rsp_tuser[1]});
         end
      end
      pending    <= pixel_queue.size();
      fail_count <= errors;
      compared   <= n_checked;
   end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
module testbench
   import mcr_pkg::*;
();

   localparam int STALL_LIMIT = 2000;
   localparam int PHASES      = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [12:0] csr_data = '0;

   int fail_count;
   int pending;
   int compared;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int requests_sent = 0;
   int quiet_cycles = 0;
   int scr_w_now = int'(WIDTH_RESET);
   int scr_h_now = int'(HEIGHT_RESET);

   int widths[PHASES]  = '{240, 4096, 1, 0, 8191, 0, 4095, 160};
   int heights[PHASES] = '{320, 4096, 1, 0, 8191, 0, 17, 4096};

   midpoint_circle_rasterizer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   circle_pixel_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending),
      .compared   (compared)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [63:0] pack_req(logic [14:0] cx, logic [14:0] cy,
                                            logic [11:0] r, logic [15:0] color);
      return {6'b0, color, r, cy, cx};
   endfunction

   task automatic issue_request(logic op, logic [63:0] data);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
   endtask

   task automatic trace_circle(int cx, int cy, int r, logic [15:0] color, int nsteps);
      issue_request(OP_START, pack_req(15'(cx), 15'(cy), 12'(r), color));
      repeat (nsteps) issue_request(OP_STEP, pack_req('0, '0, '0, '0));
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [12:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic random_circle;
      int sel;
      int r;
      int n;
      int cx;
      int cy;
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
         r = $urandom_range(0, 12);
      end else if (sel < 90) begin
         r = $urandom_range(13, 48);
      end else begin
         r = $urandom_range(0, 4095);
      end
      n = (sel < 90) ? r * 707 / 1000 + 1 + $urandom_range(0, 1) : $urandom_range(1, 4);
      if ($urandom_range(0, 3) == 0) begin
         cx = $signed(15'($urandom));
         cy = $signed(15'($urandom));
      end else begin
         cx = $urandom_range(0, (scr_w_now < 4100 ? scr_w_now : 4100) + 32) - 16;
         cy = $urandom_range(0, (scr_h_now < 4100 ? scr_h_now : 4100) + 32) - 16;
      end
      trace_circle(cx, cy, r, 16'($urandom), n);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // idle step, zero radius, negative coordinates, field extremes, restart while busy
      issue_request(OP_STEP, pack_req('0, '0, '0, '0));
      trace_circle(10, 20, 0, 16'hFFFF, 2);
      trace_circle(0, 0, 1, 16'h0000, 2);
      trace_circle(-16384, 16383, 4095, 16'h5555, 2);
      trace_circle(239, 319, 5, 16'hAAAA, 5);
      trace_circle(16383, -16384, 4095, 16'hFFFF, 1);
      trace_circle(120, 160, 7, 16'h1234, 7);

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            drain();
            scr_w_now = (p == 5) ? $urandom_range(1, 4096) : widths[p];
            scr_h_now = (p == 5) ? $urandom_range(1, 4096) : heights[p];
            write_reg(CSR_WIDTH, 13'(scr_w_now));
            write_reg(CSR_HEIGHT, 13'(scr_h_now));
            csr_valid <= 1'b0;
         end
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 47;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 47;
            end
            default: begin
               send_idle_pct = 19;
               stall_pct = 19;
            end
         endcase
         while (requests_sent < 26 + 41 * (p + 1)) begin
            if ($urandom_range(0, 99) < 85) begin
               random_circle();
            end else begin
               issue_request(1'($urandom_range(0, 1)),
                             pack_req(15'($urandom), 15'($urandom), 12'($urandom),
                                      16'($urandom)));
            end
         end
      end

      drain();
      repeat (10) @(posedge clock);
      $display("Drove %0d requests across %0d screen sizes and four idling patterns;",
               requests_sent, PHASES);
      $display("%0d pixel responses compared, %0d failures.", compared, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/mcr_pkg.sv
rtl/mcr_iter.sv
rtl/mcr_pixel.sv
rtl/midpoint_circle_rasterizer_core.sv
tb/circle_pixel_checker.sv
tb/testbench.sv
